>>> rtl/sdrt_pkg.sv
// sdrt_pkg: shared types and constants of the sigma-delta rtd thermometer
// used by sigma_delta_rtd_thermometer
`timescale 1ns / 1ps

package sdrt_pkg;

  // default moving-average depth
  localparam int unsigned AVG_DEPTH_DEF = 20;

  // field widths
  localparam int unsigned WIN_W      = 21;
  localparam int unsigned MV_W       = 12;
  localparam int unsigned OHM_W      = 16;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned TEMP_W     = 18;
  localparam int unsigned AVG_FRAC_W = 4;

  // stream and config port widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_MV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_OHMS    = 2'd2;

  // register reset values
  localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST = 21'd1300000;
  localparam logic [MV_W-1:0]  FULL_SCALE_RST    = 12'd3300;
  localparam logic [OHM_W-1:0] SENSE_OHMS_RST    = 16'd1000;

  // saturation limits
  localparam logic [MV_W-1:0]  MV_MAX  = '1;
  localparam logic [OHM_W-1:0] OHM_MAX = '1;

  // shift-add multiplier
  localparam int unsigned MUL_A_W = 30;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // inverse callendar-van dusen constants, discriminant scaled by 4e18
  localparam logic [MUL_A_W-1:0] D_SLOPE = 30'd577500000;
  localparam int unsigned RAD_W  = 46;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam logic [RAD_W-1:0]  D_BASE   = 46'd70339235560000;
  localparam logic [ROOT_W-1:0] A_SCALED = 23'd7816600;
  localparam int unsigned TDIV_W = 8;
  localparam logic [TDIV_W-1:0] TEMP_DIV  = 8'd231;
  localparam logic [TDIV_W-1:0] TEMP_HALF = 8'd115;

  // serial divider defaults
  localparam int unsigned DIV_NUM_W_DEF = 37;
  localparam int unsigned DIV_DEN_W_DEF = 21;

  // conversion sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_MV,
    ST_DIV_MV,
    ST_RING,
    ST_DIV_AVG,
    ST_MUL_R,
    ST_DIV_R,
    ST_MUL_D,
    ST_SQRT,
    ST_DIV_T,
    ST_OUT
  } state_e;

  // sequencer strobes
  typedef struct packed {
    logic in_ready;
    logic out_load;
    logic mul_load;
    logic mul_step;
    logic div_start;
    logic sqrt_start;
  } ctrl_t;

endpackage

>>> rtl/sdrt_div.sv
// sdrt_div: restoring divider, one quotient bit per cycle
// no package dependency; widths come from the instantiating module
`timescale 1ns / 1ps

module sdrt_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh_q, sh_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, sh_q[NUM_W-1]};
    fits   = trial >= {1'b0, den_q};
    sh_d   = sh_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      sh_d   = {sh_q[NUM_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = cnt_q != CNT_W'(1);
      done_d = cnt_q == CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

>>> rtl/sdrt_sqrt.sv
// sdrt_sqrt: integer square root, one root bit per cycle
// no package dependency; radicand width comes from the instantiating module
`timescale 1ns / 1ps

module sdrt_sqrt #(
  parameter int unsigned RAD_W = 46
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [RAD_W-1:0]   rad_i,
  output logic               done_o,
  output logic [RAD_W/2-1:0] root_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ROOT_W+2:0] cat;
  logic [ROOT_W+2:0] trial;
  logic              fits;

  // bring down two radicand bits, try root*4+1 against the remainder
  always_comb begin
    cat    = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial  = (ROOT_W+3)'({root_q, 2'b01});
    fits   = cat >= trial;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[RAD_W-3:0], 2'b00};
      rem_d  = fits ? (ROOT_W+1)'(cat - trial) : (ROOT_W+1)'(cat);
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      busy_d = cnt_q != CNT_W'(1);
      done_d = cnt_q == CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> rtl/sigma_delta_rtd_thermometer.sv
// A sample that closes no window gives its item next cycle, one per cycle while output is free.
// A window-closing sample starts a conversion whose length is set by NW, the numerator width
// of the bit-serial divider, with the 16-step shift-add multiplier and, on the rtd channel,
// the one-bit-per-cycle root.
// No input item is taken while a window conversion is in progress.
// Reset (async, active low) clears counters, rings, totals and averages and restores registers.
`timescale 1ns / 1ps

module sigma_delta_rtd_thermometer #(
  parameter int unsigned AVG_DEPTH = sdrt_pkg::AVG_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: [0] comparator_bit, [7:1] zero
  input  logic [sdrt_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // master side
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: [0] feedback_level, [1] active_channel, [13:2] conv_mv, [29:14] avg_rtd_mv,
  // [45:30] avg_sense_mv, [61:46] rtd_ohms, [79:62] temperature_centi, [80] ratio_error
  output logic [sdrt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser: [0] conversion_done, [1] conv_channel
  output logic [sdrt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdrt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sdrt_pkg::WIN_W-1:0]        cfg_data_i
);

  localparam int unsigned WIN_W   = sdrt_pkg::WIN_W;
  localparam int unsigned MV_W    = sdrt_pkg::MV_W;
  localparam int unsigned OHM_W   = sdrt_pkg::OHM_W;
  localparam int unsigned AVG_W   = sdrt_pkg::AVG_W;
  localparam int unsigned TEMP_W  = sdrt_pkg::TEMP_W;
  localparam int unsigned ROOT_W  = sdrt_pkg::ROOT_W;
  localparam int unsigned MUL_A_W = sdrt_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W = sdrt_pkg::MUL_B_W;
  localparam int unsigned MUL_P_W = sdrt_pkg::MUL_P_W;
  localparam int unsigned TOT_W   = $clog2(AVG_DEPTH * ((1 << MV_W) - 1) + 1);
  localparam int unsigned POS_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned MCNT_W  = $clog2(MUL_B_W);
  localparam int unsigned DIV_NW  = (TOT_W + 20 > 33) ? TOT_W + 20 : 33;
  localparam int unsigned DIV_DW  = (TOT_W > WIN_W) ? TOT_W : WIN_W;
  localparam int unsigned TNUM_W  = ROOT_W + 5;
  localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(MUL_B_W - 1);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(AVG_DEPTH - 1);

  sdrt_pkg::state_e state_q, state_d;
  sdrt_pkg::ctrl_t  ctrl;
  logic             first_q;

  // configuration registers
  logic [WIN_W-1:0] win_q;
  logic [MV_W-1:0]  fs_q;
  logic [OHM_W-1:0] so_q;

  // window and ring state
  logic [WIN_W-1:0] cnt_q, ones_q;
  logic             chan_q;
  logic [POS_W-1:0] pos_q;
  logic [MV_W-1:0]  rtd_ring_q [AVG_DEPTH];
  logic [MV_W-1:0]  sns_ring_q [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] rtd_vld_q, sns_vld_q;
  logic [TOT_W-1:0] rtd_tot_q, sns_tot_q;
  logic [AVG_W-1:0] avg_rtd_q, avg_sns_q;

  // conversion payload
  logic              bit_q, conv_ch_q, err_q, neg_q;
  logic [MV_W-1:0]   mv_q;
  logic [OHM_W-1:0]  ohms_q;
  logic [TEMP_W-1:0] temp_q;
  logic [ROOT_W-1:0] mag_q;

  // multiplier
  logic [MUL_A_W-1:0] mul_a_q, mul_a_sel;
  logic [MUL_B_W-1:0] mul_b_sel;
  logic [MUL_P_W-1:0] prod_q, prod_d;
  logic [MUL_A_W:0]   mul_sum;
  logic [MCNT_W-1:0]  mul_cnt_q;

  // shared divider and root
  logic              div_done, sqrt_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic [sdrt_pkg::RAD_W-1:0] sqrt_rad;
  logic [ROOT_W-1:0] sqrt_root;

  // output register
  logic                             out_vld_q;
  logic [sdrt_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [sdrt_pkg::OUT_TUSER_W-1:0] out_user_q, out_user_d;

  // per-sample window logic
  logic             in_acc, in_bit, close, out_free;
  logic [WIN_W-1:0] cnt_nx, ones_nx;
  logic [MV_W-1:0]  rtd_old, sns_old;
  logic [TOT_W-1:0] conv_tot;
  logic [TNUM_W-1:0] temp_num;
  logic              root_gt;
  logic [TEMP_W-1:0] quo_t;

  assign in_bit   = s_axis_tdata_i[0];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign ones_nx  = ones_q + WIN_W'(in_bit);
  assign cnt_nx   = cnt_q + WIN_W'(1);
  assign close    = (cnt_nx >= win_q) || (cnt_nx == '0);
  assign out_free = !out_vld_q || m_axis_tready_i;

  // ring read at the current position, never-written entries read as zero
  assign rtd_old  = rtd_vld_q[pos_q] ? rtd_ring_q[pos_q] : '0;
  assign sns_old  = sns_vld_q[pos_q] ? sns_ring_q[pos_q] : '0;
  assign conv_tot = conv_ch_q ? sns_tot_q : rtd_tot_q;

  // temperature numerator |a - s|*10 + half divisor
  assign temp_num = TNUM_W'({mag_q, 3'b000}) + TNUM_W'({mag_q, 1'b0})
                  + TNUM_W'(sdrt_pkg::TEMP_HALF);
  assign root_gt  = sqrt_root > sdrt_pkg::A_SCALED;
  assign quo_t    = TEMP_W'(div_quo);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdrt_pkg::ST_IDLE: begin
        if (in_acc && close) state_d = sdrt_pkg::ST_MUL_MV;
      end
      sdrt_pkg::ST_MUL_MV: begin
        if (!first_q && mul_cnt_q == MUL_LAST) state_d = sdrt_pkg::ST_DIV_MV;
      end
      sdrt_pkg::ST_DIV_MV: begin
        if (div_done) state_d = sdrt_pkg::ST_RING;
      end
      sdrt_pkg::ST_RING: begin
        state_d = sdrt_pkg::ST_DIV_AVG;
      end
      sdrt_pkg::ST_DIV_AVG: begin
        if (div_done) begin
          if (conv_ch_q)             state_d = sdrt_pkg::ST_OUT;
          else if (sns_tot_q == '0)  state_d = sdrt_pkg::ST_MUL_D;
          else                       state_d = sdrt_pkg::ST_MUL_R;
        end
      end
      sdrt_pkg::ST_MUL_R: begin
        if (!first_q && mul_cnt_q == MUL_LAST) state_d = sdrt_pkg::ST_DIV_R;
      end
      sdrt_pkg::ST_DIV_R: begin
        if (div_done) state_d = sdrt_pkg::ST_MUL_D;
      end
      sdrt_pkg::ST_MUL_D: begin
        if (!first_q && mul_cnt_q == MUL_LAST) state_d = sdrt_pkg::ST_SQRT;
      end
      sdrt_pkg::ST_SQRT: begin
        if (sqrt_done) state_d = sdrt_pkg::ST_DIV_T;
      end
      sdrt_pkg::ST_DIV_T: begin
        if (div_done) state_d = sdrt_pkg::ST_OUT;
      end
      sdrt_pkg::ST_OUT: begin
        if (out_free) state_d = sdrt_pkg::ST_IDLE;
      end
      default: state_d = sdrt_pkg::ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    ctrl = '0;
    case (state_q)
      sdrt_pkg::ST_IDLE: begin
        ctrl.in_ready = out_free;
        ctrl.out_load = out_free && s_axis_tvalid_i && !close;
      end
      sdrt_pkg::ST_MUL_MV, sdrt_pkg::ST_MUL_R, sdrt_pkg::ST_MUL_D: begin
        ctrl.mul_load = first_q;
        ctrl.mul_step = !first_q;
      end
      sdrt_pkg::ST_DIV_MV, sdrt_pkg::ST_DIV_AVG, sdrt_pkg::ST_DIV_R,
      sdrt_pkg::ST_DIV_T: begin
        ctrl.div_start = first_q;
      end
      sdrt_pkg::ST_SQRT: begin
        ctrl.sqrt_start = first_q;
      end
      sdrt_pkg::ST_OUT: begin
        ctrl.out_load = out_free;
      end
      default: ctrl = '0;
    endcase
  end

  // multiplier operands and shift-add step
  always_comb begin
    case (state_q)
      sdrt_pkg::ST_MUL_MV: begin
        mul_a_sel = MUL_A_W'(ones_q);
        mul_b_sel = MUL_B_W'(fs_q);
      end
      sdrt_pkg::ST_MUL_R: begin
        mul_a_sel = MUL_A_W'(rtd_tot_q);
        mul_b_sel = so_q;
      end
      default: begin
        mul_a_sel = sdrt_pkg::D_SLOPE;
        mul_b_sel = ohms_q;
      end
    endcase
    mul_sum = {1'b0, prod_q[MUL_P_W-1:MUL_B_W]}
            + (prod_q[0] ? {1'b0, mul_a_q} : '0);
    prod_d  = {mul_sum, prod_q[MUL_B_W-1:1]};
  end

  // divider operands
  always_comb begin
    case (state_q)
      sdrt_pkg::ST_DIV_MV: begin
        div_num = DIV_NW'(prod_q);
        div_den = DIV_DW'(cnt_q);
      end
      sdrt_pkg::ST_DIV_AVG: begin
        div_num = DIV_NW'({conv_tot, {sdrt_pkg::AVG_FRAC_W{1'b0}}});
        div_den = DIV_DW'(AVG_DEPTH);
      end
      sdrt_pkg::ST_DIV_R: begin
        div_num = DIV_NW'({prod_q, {sdrt_pkg::AVG_FRAC_W{1'b0}}});
        div_den = DIV_DW'(sns_tot_q);
      end
      default: begin
        div_num = DIV_NW'(temp_num);
        div_den = DIV_DW'(sdrt_pkg::TEMP_DIV);
      end
    endcase
  end

  assign sqrt_rad = sdrt_pkg::D_BASE - prod_q;

  sdrt_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DIV_DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  sdrt_sqrt #(
    .RAD_W (sdrt_pkg::RAD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // result item, plain sample or finished conversion
  always_comb begin
    if (state_q == sdrt_pkg::ST_OUT) begin
      out_data_d = sdrt_pkg::OUT_TDATA_W'({err_q, temp_q, ohms_q, avg_sns_q, avg_rtd_q,
                                           mv_q, chan_q, bit_q});
      out_user_d = {conv_ch_q, 1'b1};
    end else begin
      out_data_d = sdrt_pkg::OUT_TDATA_W'({1'b0, {TEMP_W{1'b0}}, {OHM_W{1'b0}}, avg_sns_q,
                                           avg_rtd_q, {MV_W{1'b0}}, chan_q, in_bit});
      out_user_d = '0;
    end
  end

  // control state, counters, rings bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdrt_pkg::ST_IDLE;
      first_q   <= 1'b0;
      win_q     <= sdrt_pkg::WINDOW_LENGTH_RST;
      fs_q      <= sdrt_pkg::FULL_SCALE_RST;
      so_q      <= sdrt_pkg::SENSE_OHMS_RST;
      cnt_q     <= '0;
      ones_q    <= '0;
      chan_q    <= 1'b0;
      pos_q     <= '0;
      rtd_vld_q <= '0;
      sns_vld_q <= '0;
      rtd_tot_q <= '0;
      sns_tot_q <= '0;
      avg_rtd_q <= '0;
      avg_sns_q <= '0;
      mul_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= state_d != state_q;

      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sdrt_pkg::REG_WINDOW_LENGTH: win_q <= cfg_data_i;
          sdrt_pkg::REG_FULL_SCALE_MV: fs_q  <= cfg_data_i[MV_W-1:0];
          sdrt_pkg::REG_SENSE_OHMS:    so_q  <= cfg_data_i[OHM_W-1:0];
          default: ;
        endcase
      end

      // count the sample; a closing window keeps its divisor in cnt_q
      if (in_acc) begin
        ones_q <= ones_nx;
        cnt_q  <= (cnt_nx == '0) ? WIN_W'(1) : cnt_nx;
      end

      // ring push, total update, channel swap
      if (state_q == sdrt_pkg::ST_RING) begin
        ones_q <= '0;
        cnt_q  <= '0;
        chan_q <= !chan_q;
        if (!chan_q) begin
          rtd_tot_q        <= rtd_tot_q - TOT_W'(rtd_old) + TOT_W'(mv_q);
          rtd_vld_q[pos_q] <= 1'b1;
        end else begin
          sns_tot_q        <= sns_tot_q - TOT_W'(sns_old) + TOT_W'(mv_q);
          sns_vld_q[pos_q] <= 1'b1;
          pos_q            <= (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
        end
      end

      // new moving average
      if (state_q == sdrt_pkg::ST_DIV_AVG && div_done) begin
        if (conv_ch_q) avg_sns_q <= AVG_W'(div_quo);
        else           avg_rtd_q <= AVG_W'(div_quo);
      end

      // multiplier step counter
      if (ctrl.mul_load)      mul_cnt_q <= '0;
      else if (ctrl.mul_step) mul_cnt_q <= mul_cnt_q + MCNT_W'(1);

      // output register
      if (ctrl.out_load)        out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  // ring storage
  always_ff @(posedge clk_i) begin
    if (state_q == sdrt_pkg::ST_RING) begin
      if (!chan_q) rtd_ring_q[pos_q] <= mv_q;
      else         sns_ring_q[pos_q] <= mv_q;
    end
  end

  // conversion payload
  always_ff @(posedge clk_i) begin
    if (in_acc) bit_q <= in_bit;

    if (ctrl.mul_load) begin
      mul_a_q <= mul_a_sel;
      prod_q  <= MUL_P_W'(mul_b_sel);
    end else if (ctrl.mul_step) begin
      prod_q  <= prod_d;
    end

    if (state_q == sdrt_pkg::ST_DIV_MV && div_done) begin
      mv_q <= (div_quo > DIV_NW'(sdrt_pkg::MV_MAX)) ? sdrt_pkg::MV_MAX : div_quo[MV_W-1:0];
    end

    if (state_q == sdrt_pkg::ST_RING) conv_ch_q <= chan_q;

    // sense conversions carry no resistance; zero sense saturates with a flag
    if (state_q == sdrt_pkg::ST_DIV_AVG && div_done) begin
      if (conv_ch_q) begin
        ohms_q <= '0;
        temp_q <= '0;
        err_q  <= 1'b0;
      end else if (sns_tot_q == '0) begin
        ohms_q <= sdrt_pkg::OHM_MAX;
        err_q  <= 1'b1;
      end else begin
        err_q  <= 1'b0;
      end
    end

    if (state_q == sdrt_pkg::ST_DIV_R && div_done) begin
      ohms_q <= (div_quo > DIV_NW'(sdrt_pkg::OHM_MAX)) ? sdrt_pkg::OHM_MAX
                                                      : div_quo[OHM_W-1:0];
    end

    // sign and magnitude of a - s
    if (state_q == sdrt_pkg::ST_SQRT && sqrt_done) begin
      neg_q <= root_gt;
      mag_q <= root_gt ? sqrt_root - sdrt_pkg::A_SCALED : sdrt_pkg::A_SCALED - sqrt_root;
    end

    // rounded quotient, halves away from zero
    if (state_q == sdrt_pkg::ST_DIV_T && div_done) begin
      temp_q <= neg_q ? (~quo_t + TEMP_W'(1)) : quo_t;
    end

    if (ctrl.out_load) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign s_axis_tready_o = ctrl.in_ready;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign cfg_ready_o     = 1'b1;

  // ones never outrun samples between windows
  a_ones_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdrt_pkg::ST_IDLE) |-> (ones_q <= cnt_q))
    else $error("ones count exceeds sample count");

  // ring position stays inside the ring
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_LAST)
    else $error("ring position out of range");

  // every ring push swaps the channel
  a_chan_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdrt_pkg::ST_RING) |=> (chan_q != $past(chan_q)))
    else $error("channel did not alternate after a conversion");

  // a ratio error only on an rtd conversion with saturated resistance
  a_err_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdrt_pkg::ST_OUT && err_q) |-> (ohms_q == sdrt_pkg::OHM_MAX && !conv_ch_q))
    else $error("ratio error without saturated rtd resistance");

  // no new item is taken while a window conversion runs
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sdrt_pkg::ST_IDLE) |-> !in_acc)
    else $error("item accepted during a conversion");

endmodule
